[src/ars_pkg.sv]
`default_nettype none

package ars_pkg;

  localparam int unsigned VecW = 32;
  localparam int unsigned RegW = 31;
  localparam int unsigned IdxW = 3;

  typedef enum logic [IdxW-1:0] {
    REG_TARGET_RADIUS  = 3'd0,
    REG_SLOW_RADIUS    = 3'd1,
    REG_MAX_SPEED      = 3'd2,
    REG_MAX_ACCEL      = 3'd3,
    REG_TIME_TO_TARGET = 3'd4
  } reg_e;

  // 0.1 in Q16.16
  localparam logic [RegW-1:0] TimeToTargetReset = 31'd6554;

  typedef struct packed {
    logic signed [VecW-1:0] char_pos_x;
    logic signed [VecW-1:0] char_pos_y;
    logic signed [VecW-1:0] char_pos_z;
    logic signed [VecW-1:0] target_pos_x;
    logic signed [VecW-1:0] target_pos_y;
    logic signed [VecW-1:0] target_pos_z;
    logic signed [VecW-1:0] char_vel_x;
    logic signed [VecW-1:0] char_vel_y;
    logic signed [VecW-1:0] char_vel_z;
  } in_t;

  typedef struct packed {
    logic signed [VecW-1:0] accel_x;
    logic signed [VecW-1:0] accel_y;
    logic signed [VecW-1:0] accel_z;
    logic                   arrived;
  } out_t;

endpackage

`default_nettype wire

[src/ars_div_pipe.sv]
`default_nettype none

module ars_div_pipe #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned QBits = 31,
  parameter int unsigned SideW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [Lanes-1:0][63:0]       num_i,
  input  logic [31:0]                  den_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic [Lanes-1:0][QBits-1:0]  quo_o,
  output logic [SideW-1:0]             side_o
);

  localparam int unsigned RemW = 64;
  localparam int unsigned DenW = 32;

  logic                          v_q [QBits];
  logic [Lanes-1:0][RemW-1:0]    r_q [QBits];
  logic [Lanes-1:0][QBits-1:0]   q_q [QBits];
  logic [DenW-1:0]               d_q [QBits];
  logic [SideW-1:0]              s_q [QBits];

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < QBits; g++) begin : g_stage
    localparam int unsigned Shift = QBits - 1 - g;
    logic                        pv;
    logic [Lanes-1:0][RemW-1:0]  pr;
    logic [Lanes-1:0][QBits-1:0] pq;
    logic [DenW-1:0]             pd;
    logic [SideW-1:0]            ps;
    logic [RemW-1:0]             dsh;
    logic [Lanes-1:0][RemW-1:0]  nr;
    logic [Lanes-1:0][QBits-1:0] nq;

    if (g == 0) begin : g_head
      assign pv = valid_i;
      assign pr = num_i;
      assign pq = '0;
      assign pd = den_i;
      assign ps = side_i;
    end else begin : g_body
      assign pv = v_q[g-1];
      assign pr = r_q[g-1];
      assign pq = q_q[g-1];
      assign pd = d_q[g-1];
      assign ps = s_q[g-1];
    end

    assign dsh = RemW'(pd) << Shift;

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        if (pr[l] >= dsh) begin
          nr[l] = pr[l] - dsh;
          nq[l] = {pq[l][QBits-2:0], 1'b1};
        end else begin
          nr[l] = pr[l];
          nq[l] = {pq[l][QBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[g] <= nr;
      q_q[g] <= nq;
      d_q[g] <= pd;
      s_q[g] <= ps;
    end
  end

  assign valid_o = v_q[QBits-1];
  assign quo_o   = q_q[QBits-1];
  assign side_o  = s_q[QBits-1];

endmodule

`default_nettype wire

[src/arrive_steering.sv]
`default_nettype none

// Arrive steering, fully pipelined: one beat accepted every cycle, busy_o never rises.
// The pipeline holds two 32-stage square roots and four restoring dividers at one
// quotient bit a stage.
// The receiver cannot stall; done_o marks each result for exactly one cycle.
// Reset clears all valid bits and loads the register reset values; no clearing pass.

module arrive_steering (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  ars_pkg::in_t                 in_i,
  output logic                         done_o,
  output ars_pkg::out_t                res_o,
  input  logic                         cfg_we_i,
  input  logic [ars_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [ars_pkg::RegW-1:0]     cfg_wdata_i
);

  import ars_pkg::*;

  localparam int unsigned SqSteps = 32;

  typedef struct packed {
    logic             arr;
    logic             slow;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [2:0][31:0] vel;
  } side_a_t;

  typedef struct packed {
    side_a_t     a;
    logic [31:0] dlen;
  } side_b_t;

  typedef struct packed {
    logic             arr;
    logic             dzero;
    logic [2:0]       neg;
    logic [2:0][31:0] vel;
  } side_c_t;

  typedef struct packed {
    logic       arr;
    logic [2:0] neg;
    logic [2:0] zero;
    logic [2:0] ovf;
  } side_d_t;

  typedef struct packed {
    logic             arr;
    logic             resc;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } side_e_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_t;

  // saturating signed subtract t - c
  function automatic logic [31:0] sat_sub(logic [31:0] t, logic [31:0] c);
    logic [32:0] w;
    w = {t[31], t} - {c[31], c};
    if (w[32] != w[31]) return w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return w[31:0];
  endfunction

  // one step of the digit-by-digit integer square root
  function automatic sqrt_t sqrt_step(sqrt_t x, logic [63:0] b);
    sqrt_t y;
    if (x.n >= x.r + b) begin
      y.n = x.n - (x.r + b);
      y.r = (x.r >> 1) + b;
    end else begin
      y.n = x.n;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; squared bounds are registered from them in the next cycle, well
  // before any beat reaches the compare stages.
  // ---------------------------------------------------------------------------
  logic [RegW-1:0] tr_q, sr_q, ms_q, mx_q, ttt_q;
  logic [61:0]     tr2_q, sr2_q, mx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q  <= '0;
      sr_q  <= '0;
      ms_q  <= '0;
      mx_q  <= '0;
      ttt_q <= TimeToTargetReset;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_TARGET_RADIUS:  tr_q  <= cfg_wdata_i;
        REG_SLOW_RADIUS:    sr_q  <= cfg_wdata_i;
        REG_MAX_SPEED:      ms_q  <= cfg_wdata_i;
        REG_MAX_ACCEL:      mx_q  <= cfg_wdata_i;
        REG_TIME_TO_TARGET: ttt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tr2_q <= {31'b0, tr_q} * {31'b0, tr_q};
    sr2_q <= {31'b0, sr_q} * {31'b0, sr_q};
    mx2_q <= {31'b0, mx_q} * {31'b0, mx_q};
  end

  // ---------------------------------------------------------------------------
  // Handshake: the pipeline never stalls, so a beat is taken whenever offered.
  // ---------------------------------------------------------------------------
  logic busy, acc;
  assign busy   = 1'b0;
  assign busy_o = busy;
  assign acc    = start_i && !busy;

  logic [2:0][31:0] in_c, in_tg, in_v;
  assign in_c  = {in_i.char_pos_z,   in_i.char_pos_y,   in_i.char_pos_x};
  assign in_tg = {in_i.target_pos_z, in_i.target_pos_y, in_i.target_pos_x};
  assign in_v  = {in_i.char_vel_z,   in_i.char_vel_y,   in_i.char_vel_x};

  // ---------------------------------------------------------------------------
  // Front end: direction, magnitudes, squares, sum, radius tests
  // ---------------------------------------------------------------------------
  logic             a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic [2:0][31:0] a_d_q, a_vel_q;
  logic [2:0][31:0] b_mag_q, b_vel_q, c_mag_q, c_vel_q, d_mag_q, d_vel_q;
  logic [2:0]       b_neg_q, c_neg_q, d_neg_q;
  logic [2:0][63:0] c_sq_q;
  logic [63:0]      d_s_q, e_s_q;
  side_a_t          e_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a_d_q[k]   <= sat_sub(in_tg[k], in_c[k]);
      b_neg_q[k] <= a_d_q[k][31];
      b_mag_q[k] <= a_d_q[k][31] ? 32'd0 - a_d_q[k] : a_d_q[k];
      c_sq_q[k]  <= {32'b0, b_mag_q[k]} * {32'b0, b_mag_q[k]};
    end
    a_vel_q <= in_v;
    b_vel_q <= a_vel_q;
    c_mag_q <= b_mag_q;
    c_neg_q <= b_neg_q;
    c_vel_q <= b_vel_q;
    d_s_q   <= c_sq_q[0] + c_sq_q[1] + c_sq_q[2];
    d_mag_q <= c_mag_q;
    d_neg_q <= c_neg_q;
    d_vel_q <= c_vel_q;
    e_s_q         <= d_s_q;
    e_side_q.arr  <= d_s_q < 64'(tr2_q);
    e_side_q.slow <= (sr_q != '0) && (d_s_q <= 64'(sr2_q));
    e_side_q.neg  <= d_neg_q;
    e_side_q.mag  <= d_mag_q;
    e_side_q.vel  <= d_vel_q;
  end

  // ---------------------------------------------------------------------------
  // Distance: square root of the squared length
  // ---------------------------------------------------------------------------
  logic    s1_v_q    [SqSteps];
  sqrt_t   s1_x_q    [SqSteps];
  side_a_t s1_side_q [SqSteps];

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt1
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic    pv;
    sqrt_t   px;
    side_a_t ps;
    if (g == 0) begin : g_head
      assign pv   = e_v_q;
      assign px.n = e_s_q;
      assign px.r = '0;
      assign ps   = e_side_q;
    end else begin : g_body
      assign pv = s1_v_q[g-1];
      assign px = s1_x_q[g-1];
      assign ps = s1_side_q[g-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_v_q[g] <= 1'b0;
      end else begin
        s1_v_q[g] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      s1_x_q[g]    <= sqrt_step(px, Bit);
      s1_side_q[g] <= ps;
    end
  end

  // ---------------------------------------------------------------------------
  // Target speed: top speed * distance / slow-down radius inside that radius
  // ---------------------------------------------------------------------------
  logic        f_v_q;
  logic [63:0] f_num_q;
  side_b_t     f_side_q;

  always_ff @(posedge clk_i) begin
    f_num_q       <= {33'b0, ms_q} * {32'b0, s1_x_q[SqSteps-1].r[31:0]};
    f_side_q.a    <= s1_side_q[SqSteps-1];
    f_side_q.dlen <= s1_x_q[SqSteps-1].r[31:0];
  end

  logic             ds_v;
  logic [0:0][30:0] ds_quo;
  side_b_t          ds_side;

  ars_div_pipe #(
    .Lanes (1),
    .QBits (31),
    .SideW ($bits(side_b_t))
  ) u_div_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v_q),
    .num_i   (f_num_q),
    .den_i   ({1'b0, sr_q}),
    .side_i  (f_side_q),
    .valid_o (ds_v),
    .quo_o   (ds_quo),
    .side_o  (ds_side)
  );

  logic             g_v_q, h_v_q;
  logic [30:0]      g_speed_d;
  logic [30:0]      g_speed_q;
  side_b_t          g_side_q;
  logic [2:0][63:0] h_num_q;
  logic [31:0]      h_dist_q;
  side_c_t          h_side_q;

  // g_speed_q must pick up the divider output of its own beat
  always_comb begin
    g_speed_d = ds_side.a.slow ? ds_quo[0] : ms_q;
  end

  always_ff @(posedge clk_i) begin
    g_speed_q <= g_speed_d;
    g_side_q  <= ds_side;
    for (int k = 0; k < 3; k++) begin
      h_num_q[k] <= {33'b0, g_speed_q} * {32'b0, g_side_q.a.mag[k]};
    end
    h_dist_q       <= g_side_q.dlen;
    h_side_q.arr   <= g_side_q.a.arr;
    h_side_q.dzero <= g_side_q.dlen == '0;
    h_side_q.neg   <= g_side_q.a.neg;
    h_side_q.vel   <= g_side_q.a.vel;
  end

  // ---------------------------------------------------------------------------
  // Desired velocity: |d_k| * speed / distance, sign restored afterwards
  // ---------------------------------------------------------------------------
  logic             dw_v;
  logic [2:0][30:0] dw_quo;
  side_c_t          dw_side;

  ars_div_pipe #(
    .Lanes (3),
    .QBits (31),
    .SideW ($bits(side_c_t))
  ) u_div_want (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_v_q),
    .num_i   (h_num_q),
    .den_i   (h_dist_q),
    .side_i  (h_side_q),
    .valid_o (dw_v),
    .quo_o   (dw_quo),
    .side_o  (dw_side)
  );

  logic             i_v_q, j_v_q, k_v_q;
  logic [2:0][31:0] i_want_q, i_vel_q;
  logic             i_arr_q, j_arr_q, k_arr_q;
  logic [2:0][32:0] j_diff_q;
  logic [2:0][31:0] k_dmag_q;
  logic [2:0]       k_neg_q, k_zero_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (dw_side.dzero) begin
        i_want_q[k] <= '0;
      end else if (dw_side.neg[k]) begin
        i_want_q[k] <= 32'd0 - {1'b0, dw_quo[k]};
      end else begin
        i_want_q[k] <= {1'b0, dw_quo[k]};
      end
      j_diff_q[k] <= {i_want_q[k][31], i_want_q[k]} - {i_vel_q[k][31], i_vel_q[k]};
      k_neg_q[k]  <= j_diff_q[k][32];
      k_zero_q[k] <= j_diff_q[k] == '0;
      k_dmag_q[k] <= j_diff_q[k][32] ? 32'(33'd0 - j_diff_q[k]) : j_diff_q[k][31:0];
    end
    i_vel_q <= dw_side.vel;
    i_arr_q <= dw_side.arr;
    j_arr_q <= i_arr_q;
    k_arr_q <= j_arr_q;
  end

  // ---------------------------------------------------------------------------
  // Acceleration: |diff| * 65536 / closing time; quotients of 2^32 and above
  // (and a zero time) flag overflow up front and saturate
  // ---------------------------------------------------------------------------
  logic [2:0][63:0] k_num;
  side_d_t          k_side;

  always_comb begin
    k_side.arr  = k_arr_q;
    k_side.neg  = k_neg_q;
    k_side.zero = k_zero_q;
    for (int k = 0; k < 3; k++) begin
      k_num[k]      = {16'b0, k_dmag_q[k], 16'b0};
      k_side.ovf[k] = {16'b0, k_dmag_q[k][31:16]} >= {1'b0, ttt_q};
    end
  end

  logic             da_v;
  logic [2:0][31:0] da_quo;
  side_d_t          da_side;

  ars_div_pipe #(
    .Lanes (3),
    .QBits (32),
    .SideW ($bits(side_d_t))
  ) u_div_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (k_v_q),
    .num_i   (k_num),
    .den_i   ({1'b0, ttt_q}),
    .side_i  (k_side),
    .valid_o (da_v),
    .quo_o   (da_quo),
    .side_o  (da_side)
  );

  logic             l_v_q, m_v_q, n_v_q, o_v_q, p_v_q;
  logic [2:0][31:0] l_a_q, m_mag_q, n_mag_q, o_mag_q;
  logic [2:0]       m_neg_q, n_neg_q, o_neg_q;
  logic             l_arr_q, m_arr_q, n_arr_q, o_arr_q;
  logic [2:0][63:0] n_sq_q;
  logic [63:0]      o_s_q, p_s_q;
  side_e_t          p_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (da_side.zero[k]) begin
        l_a_q[k] <= '0;
      end else if (da_side.ovf[k]) begin
        l_a_q[k] <= da_side.neg[k] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (da_side.neg[k]) begin
        l_a_q[k] <= (da_quo[k] > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - da_quo[k];
      end else begin
        l_a_q[k] <= da_quo[k][31] ? 32'h7fff_ffff : da_quo[k];
      end
      m_neg_q[k] <= l_a_q[k][31];
      m_mag_q[k] <= l_a_q[k][31] ? 32'd0 - l_a_q[k] : l_a_q[k];
      n_sq_q[k]  <= {32'b0, m_mag_q[k]} * {32'b0, m_mag_q[k]};
    end
    l_arr_q <= da_side.arr;
    m_arr_q <= l_arr_q;
    n_arr_q <= m_arr_q;
    n_mag_q <= m_mag_q;
    n_neg_q <= m_neg_q;
    o_s_q   <= n_sq_q[0] + n_sq_q[1] + n_sq_q[2];
    o_arr_q <= n_arr_q;
    o_mag_q <= n_mag_q;
    o_neg_q <= n_neg_q;
    p_s_q         <= o_s_q;
    p_side_q.arr  <= o_arr_q;
    p_side_q.resc <= o_s_q > 64'(mx2_q);
    p_side_q.neg  <= o_neg_q;
    p_side_q.mag  <= o_mag_q;
  end

  // ---------------------------------------------------------------------------
  // Acceleration length for the limit
  // ---------------------------------------------------------------------------
  logic    s2_v_q    [SqSteps];
  sqrt_t   s2_x_q    [SqSteps];
  side_e_t s2_side_q [SqSteps];

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt2
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic    pv;
    sqrt_t   px;
    side_e_t ps;
    if (g == 0) begin : g_head
      assign pv   = p_v_q;
      assign px.n = p_s_q;
      assign px.r = '0;
      assign ps   = p_side_q;
    end else begin : g_body
      assign pv = s2_v_q[g-1];
      assign px = s2_x_q[g-1];
      assign ps = s2_side_q[g-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s2_v_q[g] <= 1'b0;
      end else begin
        s2_v_q[g] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      s2_x_q[g]    <= sqrt_step(px, Bit);
      s2_side_q[g] <= ps;
    end
  end

  // ---------------------------------------------------------------------------
  // Rescale: |a_k| * acceleration limit / length
  // ---------------------------------------------------------------------------
  logic             q_v_q;
  logic [2:0][63:0] q_num_q;
  logic [31:0]      q_len_q;
  side_e_t          q_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      q_num_q[k] <= {33'b0, mx_q} * {32'b0, s2_side_q[SqSteps-1].mag[k]};
    end
    q_len_q  <= s2_x_q[SqSteps-1].r[31:0];
    q_side_q <= s2_side_q[SqSteps-1];
  end

  logic             dr_v;
  logic [2:0][30:0] dr_quo;
  side_e_t          dr_side;

  ars_div_pipe #(
    .Lanes (3),
    .QBits (31),
    .SideW ($bits(side_e_t))
  ) u_div_rescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_v_q),
    .num_i   (q_num_q),
    .den_i   (q_len_q),
    .side_i  (q_side_q),
    .valid_o (dr_v),
    .quo_o   (dr_quo),
    .side_o  (dr_side)
  );

  // ---------------------------------------------------------------------------
  // Output beat: arrived forces a zero vector, else pick scaled or plain value
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] r_acc_d;
  out_t             res_q;
  logic             done_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dr_side.arr) begin
        r_acc_d[k] = '0;
      end else if (dr_side.resc) begin
        r_acc_d[k] = dr_side.neg[k] ? 32'd0 - {1'b0, dr_quo[k]} : {1'b0, dr_quo[k]};
      end else begin
        r_acc_d[k] = dr_side.neg[k] ? 32'd0 - dr_side.mag[k] : dr_side.mag[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.accel_x <= r_acc_d[0];
    res_q.accel_y <= r_acc_d[1];
    res_q.accel_z <= r_acc_d[2];
    res_q.arrived <= dr_side.arr;
  end

  // valid bits travel with every stage; clear them all on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
      f_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
      h_v_q  <= 1'b0;
      i_v_q  <= 1'b0;
      j_v_q  <= 1'b0;
      k_v_q  <= 1'b0;
      l_v_q  <= 1'b0;
      m_v_q  <= 1'b0;
      n_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
      p_v_q  <= 1'b0;
      q_v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_v_q  <= acc;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      e_v_q  <= d_v_q;
      f_v_q  <= s1_v_q[SqSteps-1];
      g_v_q  <= ds_v;
      h_v_q  <= g_v_q;
      i_v_q  <= dw_v;
      j_v_q  <= i_v_q;
      k_v_q  <= j_v_q;
      l_v_q  <= da_v;
      m_v_q  <= l_v_q;
      n_v_q  <= m_v_q;
      o_v_q  <= n_v_q;
      p_v_q  <= o_v_q;
      q_v_q  <= s2_v_q[SqSteps-1];
      done_q <= dr_v;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
